[rtl/core/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants for hue sector decode, ramp division and brightness scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W    = 9;
    localparam int CHAN_W   = 8;
    localparam int FRAC_W   = 6;
    localparam int SECTOR_W = 3;
    localparam int RAMP_W   = 14;
    localparam int SCALE_W  = 16;

    localparam logic [HUE_W-1:0]  HUE_SECTOR = 9'd60;
    localparam logic [HUE_W-1:0]  HUE_LIMIT  = 9'd360;
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // floor(x / 60) == ((x >> 2) * DIV15_RECIP) >> DIV15_SHIFT for x < 2**14
    localparam logic [12:0] DIV15_RECIP = 13'd4370;
    localparam int          DIV15_SHIFT = 16;

    localparam logic [SECTOR_W-1:0] SECTOR_RED_GREEN    = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_RED    = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_BLUE   = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_GREEN   = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_RED     = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_RED_BLUE     = 3'd5;

endpackage

`default_nettype wire

[rtl/core/hsv2rgb_scale.sv]
// ----------------------------------------------------------------------------
// HSV to RGB channel scaler
// Divides a 16-bit brightness product by 255 with truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_scale (
    input  wire logic [hsv2rgb_pkg::SCALE_W-1:0] product,
    output logic      [hsv2rgb_pkg::CHAN_W-1:0]  quotient
);

    logic [hsv2rgb_pkg::CHAN_W-1:0]  q_est;
    logic [hsv2rgb_pkg::SCALE_W-1:0] q_times_full;
    logic [hsv2rgb_pkg::SCALE_W-1:0] remainder;
    logic                            carry;

    // product / 256 undershoots product / 255 by at most one
    assign q_est        = product[hsv2rgb_pkg::SCALE_W-1:hsv2rgb_pkg::CHAN_W];
    assign q_times_full = {q_est, {hsv2rgb_pkg::CHAN_W{1'b0}}}
                        - {{hsv2rgb_pkg::CHAN_W{1'b0}}, q_est};
    assign remainder    = product - q_times_full;
    assign carry        = remainder >= {{hsv2rgb_pkg::CHAN_W{1'b0}}, hsv2rgb_pkg::FULL_SCALE};
    assign quotient     = q_est + {{(hsv2rgb_pkg::CHAN_W-1){1'b0}}, carry};

endmodule

`default_nettype wire

[rtl/core/hsv_to_rgb_converter_core.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter core: five register stages, an accepted item passes
// through stage registers s1 to s4 and the output register to m_valid.
// Throughput one item per cycle if m_ready; the 8x8 multipliers set the depth.
// Synchronous active-low reset empties the pipeline and sets brightness 255.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hsv2rgb_pkg::CHAN_W-1:0]    cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]     s_hue,
    input  wire logic [hsv2rgb_pkg::CHAN_W-1:0]    s_sat,
    input  wire logic [hsv2rgb_pkg::CHAN_W-1:0]    s_val,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [hsv2rgb_pkg::CHAN_W-1:0]    m_red,
    output logic      [hsv2rgb_pkg::CHAN_W-1:0]    m_green,
    output logic      [hsv2rgb_pkg::CHAN_W-1:0]    m_blue,
    output logic                                   m_hue_invalid
);

    localparam int CW = hsv2rgb_pkg::CHAN_W;
    localparam int SW = hsv2rgb_pkg::SECTOR_W;
    localparam int FW = hsv2rgb_pkg::FRAC_W;
    localparam int RW = hsv2rgb_pkg::RAMP_W;
    localparam int PW = hsv2rgb_pkg::SCALE_W;
    localparam int HW = hsv2rgb_pkg::HUE_W;

    logic [CW-1:0] max_brightness_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1: sector decode and bottom level
    logic [SW-1:0]   s1_sector_next;
    logic [HW-1:0]   s1_base;
    logic [HW-1:0]   s1_offset;
    logic [2*CW-1:0] s1_bottom_prod;
    logic [SW-1:0]   s1_sector_reg;
    logic [FW-1:0]   s1_frac_reg;
    logic [CW-1:0]   s1_top_reg;
    logic [CW-1:0]   s1_bottom_reg;
    logic            s1_invalid_reg;

    // stage 2: ramp products
    logic [CW-1:0] s2_span;
    logic [FW-1:0] s2_rest;
    logic [RW-1:0] s2_rise_prod_next;
    logic [RW-1:0] s2_fall_prod_next;
    logic [RW-1:0] s2_rise_prod_reg;
    logic [RW-1:0] s2_fall_prod_reg;
    logic [SW-1:0] s2_sector_reg;
    logic [CW-1:0] s2_top_reg;
    logic [CW-1:0] s2_bottom_reg;
    logic          s2_invalid_reg;

    // stage 3: divide by 60
    logic [24:0]   s3_rise_recip;
    logic [24:0]   s3_fall_recip;
    logic [CW-1:0] s3_rising_next;
    logic [CW-1:0] s3_falling_next;
    logic [CW-1:0] s3_rising_reg;
    logic [CW-1:0] s3_falling_reg;
    logic [SW-1:0] s3_sector_reg;
    logic [CW-1:0] s3_top_reg;
    logic [CW-1:0] s3_bottom_reg;
    logic          s3_invalid_reg;

    // stage 4: route and brightness product
    logic [CW-1:0] s4_r, s4_g, s4_b;
    logic [PW-1:0] s4_red_prod_reg;
    logic [PW-1:0] s4_green_prod_reg;
    logic [PW-1:0] s4_blue_prod_reg;
    logic          s4_invalid_reg;

    // stage 5: divide by 255 into the output register
    logic [CW-1:0] red_next, green_next, blue_next;
    logic [CW-1:0] red_reg, green_reg, blue_reg;
    logic          invalid_reg;

    assign cfg_ready = 1'b1;

    assign en5     = !out_valid_reg || m_ready;
    assign en4     = !s4_valid_reg  || en5;
    assign en3     = !s3_valid_reg  || en4;
    assign en2     = !s2_valid_reg  || en3;
    assign en1     = !s1_valid_reg  || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_brightness_reg <= hsv2rgb_pkg::FULL_SCALE;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            s3_valid_reg       <= 1'b0;
            s4_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_brightness_reg <= cfg_data;
            end
            if (en1) s1_valid_reg  <= s_valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) s3_valid_reg  <= s2_valid_reg;
            if (en4) s4_valid_reg  <= s3_valid_reg;
            if (en5) out_valid_reg <= s4_valid_reg;
        end
    end

    always_comb begin
        priority if (s_hue >= HW'(5 * hsv2rgb_pkg::HUE_SECTOR)) begin
            s1_sector_next = hsv2rgb_pkg::SECTOR_RED_BLUE;
            s1_base        = HW'(5 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (s_hue >= HW'(4 * hsv2rgb_pkg::HUE_SECTOR)) begin
            s1_sector_next = hsv2rgb_pkg::SECTOR_BLUE_RED;
            s1_base        = HW'(4 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (s_hue >= HW'(3 * hsv2rgb_pkg::HUE_SECTOR)) begin
            s1_sector_next = hsv2rgb_pkg::SECTOR_BLUE_GREEN;
            s1_base        = HW'(3 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (s_hue >= HW'(2 * hsv2rgb_pkg::HUE_SECTOR)) begin
            s1_sector_next = hsv2rgb_pkg::SECTOR_GREEN_BLUE;
            s1_base        = HW'(2 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (s_hue >= hsv2rgb_pkg::HUE_SECTOR) begin
            s1_sector_next = hsv2rgb_pkg::SECTOR_GREEN_RED;
            s1_base        = hsv2rgb_pkg::HUE_SECTOR;
        end else begin
            s1_sector_next = hsv2rgb_pkg::SECTOR_RED_GREEN;
            s1_base        = '0;
        end
    end

    assign s1_offset      = s_hue - s1_base;
    assign s1_bottom_prod = (hsv2rgb_pkg::FULL_SCALE - s_sat) * s_val;

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_sector_reg  <= s1_sector_next;
            s1_frac_reg    <= s1_offset[FW-1:0];
            s1_top_reg     <= s_val;
            s1_bottom_reg  <= s1_bottom_prod[2*CW-1:CW];
            s1_invalid_reg <= s_hue >= hsv2rgb_pkg::HUE_LIMIT;
        end
    end

    assign s2_span           = s1_top_reg - s1_bottom_reg;
    assign s2_rest           = FW'(hsv2rgb_pkg::HUE_SECTOR) - s1_frac_reg;
    assign s2_rise_prod_next = RW'(s2_span * s1_frac_reg);
    assign s2_fall_prod_next = RW'(s2_span * s2_rest);

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_rise_prod_reg <= s2_rise_prod_next;
            s2_fall_prod_reg <= s2_fall_prod_next;
            s2_sector_reg    <= s1_sector_reg;
            s2_top_reg       <= s1_top_reg;
            s2_bottom_reg    <= s1_bottom_reg;
            s2_invalid_reg   <= s1_invalid_reg;
        end
    end

    assign s3_rise_recip   = s2_rise_prod_reg[RW-1:2] * hsv2rgb_pkg::DIV15_RECIP;
    assign s3_fall_recip   = s2_fall_prod_reg[RW-1:2] * hsv2rgb_pkg::DIV15_RECIP;
    assign s3_rising_next  = s3_rise_recip[hsv2rgb_pkg::DIV15_SHIFT +: CW] + s2_bottom_reg;
    assign s3_falling_next = s3_fall_recip[hsv2rgb_pkg::DIV15_SHIFT +: CW] + s2_bottom_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_rising_reg  <= s3_rising_next;
            s3_falling_reg <= s3_falling_next;
            s3_sector_reg  <= s2_sector_reg;
            s3_top_reg     <= s2_top_reg;
            s3_bottom_reg  <= s2_bottom_reg;
            s3_invalid_reg <= s2_invalid_reg;
        end
    end

    always_comb begin
        unique case (s3_sector_reg)
            hsv2rgb_pkg::SECTOR_RED_GREEN: begin
                s4_r = s3_top_reg;     s4_g = s3_rising_reg;  s4_b = s3_bottom_reg;
            end
            hsv2rgb_pkg::SECTOR_GREEN_RED: begin
                s4_r = s3_falling_reg; s4_g = s3_top_reg;     s4_b = s3_bottom_reg;
            end
            hsv2rgb_pkg::SECTOR_GREEN_BLUE: begin
                s4_r = s3_bottom_reg;  s4_g = s3_top_reg;     s4_b = s3_rising_reg;
            end
            hsv2rgb_pkg::SECTOR_BLUE_GREEN: begin
                s4_r = s3_bottom_reg;  s4_g = s3_falling_reg; s4_b = s3_top_reg;
            end
            hsv2rgb_pkg::SECTOR_BLUE_RED: begin
                s4_r = s3_rising_reg;  s4_g = s3_bottom_reg;  s4_b = s3_top_reg;
            end
            default: begin
                s4_r = s3_top_reg;     s4_g = s3_bottom_reg;  s4_b = s3_falling_reg;
            end
        endcase
        if (s3_invalid_reg) begin
            s4_r = '0;
            s4_g = '0;
            s4_b = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_red_prod_reg   <= s4_r * max_brightness_reg;
            s4_green_prod_reg <= s4_g * max_brightness_reg;
            s4_blue_prod_reg  <= s4_b * max_brightness_reg;
            s4_invalid_reg    <= s3_invalid_reg;
        end
    end

    hsv2rgb_scale u_scale_red (
        .product  (s4_red_prod_reg),
        .quotient (red_next)
    );

    hsv2rgb_scale u_scale_green (
        .product  (s4_green_prod_reg),
        .quotient (green_next)
    );

    hsv2rgb_scale u_scale_blue (
        .product  (s4_blue_prod_reg),
        .quotient (blue_next)
    );

    always_ff @(posedge aclk) begin
        if (en5) begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            invalid_reg <= s4_invalid_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_hue_invalid = invalid_reg;

endmodule

`default_nettype wire

[rtl/core/hsv2rgb_checker.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter port checker
// Watches the converter ports for output hold, flag coding and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic [hsv2rgb_pkg::HUE_W-1:0]  s_hue,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0] m_red,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0] m_green,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0] m_blue,
    input wire logic                           m_hue_invalid
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_hue_invalid))
        else $error("output item changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hue_invalid |-> m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("invalid hue item carries nonzero channels");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_invalid_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_hue >= hsv2rgb_pkg::HUE_LIMIT && m_ready)
            ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
            |=> m_valid && m_hue_invalid)
        else $error("invalid hue item did not arrive after five cycles");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (.*);

`default_nettype wire

[verif/tb_hsv_to_rgb_converter_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the HSV to RGB converter core
// Drives pixels through the valid/ready input channel, predicts each RGB item
// with an integer sector/ramp/brightness model, and checks results in order.
// Covers sector starts, field extremes, out-of-range hue, brightness writes,
// and random traffic under sender and receiver idling.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter_core;

    import hsv2rgb_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              hue_invalid;
    } rgb_pixel_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CHAN_W-1:0] cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [HUE_W-1:0]  s_hue = '0;
    logic [CHAN_W-1:0] s_sat = '0;
    logic [CHAN_W-1:0] s_val = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CHAN_W-1:0] m_red;
    logic [CHAN_W-1:0] m_green;
    logic [CHAN_W-1:0] m_blue;
    logic              m_hue_invalid;

    rgb_pixel_t        pending_rgb[$];
    rgb_pixel_t        oldest_rgb;
    logic [CHAN_W-1:0] brightness = FULL_SCALE;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatch_count = 0;

    hsv_to_rgb_converter_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hue         (s_hue),
        .s_sat         (s_sat),
        .s_val         (s_val),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_hue_invalid (m_hue_invalid)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic rgb_pixel_t predict_rgb(input logic [HUE_W-1:0] hue,
                                               input logic [CHAN_W-1:0] sat,
                                               input logic [CHAN_W-1:0] val,
                                               input logic [CHAN_W-1:0] bright);
        int unsigned        top;
        int unsigned        bottom;
        int unsigned        span;
        int unsigned        frac;
        int unsigned        rising;
        int unsigned        falling;
        int unsigned        r;
        int unsigned        g;
        int unsigned        b;
        logic [SECTOR_W-1:0] sector;
        rgb_pixel_t         pix;

        pix = '0;
        if (hue >= HUE_LIMIT) begin
            pix.hue_invalid = 1'b1;
            return pix;
        end
        top     = val;
        bottom  = ((FULL_SCALE - sat) * val) >> 8;
        span    = top - bottom;
        frac    = hue % HUE_SECTOR;
        rising  = (span * frac) / HUE_SECTOR + bottom;
        falling = (span * (HUE_SECTOR - frac)) / HUE_SECTOR + bottom;
        sector  = SECTOR_W'(hue / HUE_SECTOR);
        case (sector)
            SECTOR_RED_GREEN: begin
                r = top;     g = rising;  b = bottom;
            end
            SECTOR_GREEN_RED: begin
                r = falling; g = top;     b = bottom;
            end
            SECTOR_GREEN_BLUE: begin
                r = bottom;  g = top;     b = rising;
            end
            SECTOR_BLUE_GREEN: begin
                r = bottom;  g = falling; b = top;
            end
            SECTOR_BLUE_RED: begin
                r = rising;  g = bottom;  b = top;
            end
            default: begin
                r = top;     g = bottom;  b = falling;
            end
        endcase
        pix.red   = CHAN_W'(((r & 8'hFF) * bright) / FULL_SCALE);
        pix.green = CHAN_W'(((g & 8'hFF) * bright) / FULL_SCALE);
        pix.blue  = CHAN_W'(((b & 8'hFF) * bright) / FULL_SCALE);
        return pix;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // receiver stall
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual r=%0d g=%0d b=%0d inv=%0d",
                         $time, m_red, m_green, m_blue, m_hue_invalid);
                mismatch_count++;
            end else begin
                oldest_rgb = pending_rgb.pop_front();
                check_field("red", oldest_rgb.red, m_red);
                check_field("green", oldest_rgb.green, m_green);
                check_field("blue", oldest_rgb.blue, m_blue);
                check_field("hue_invalid", oldest_rgb.hue_invalid, m_hue_invalid);
            end
        end
    end

    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CHAN_W-1:0] sat,
                              input logic [CHAN_W-1:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_hue   <= hue;
        s_sat   <= sat;
        s_val   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rgb.insert(pending_rgb.size(), predict_rgb(hue, sat, val, brightness));
    endtask

    // hold off input until the pipeline has drained
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rgb.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_brightness(input logic [CHAN_W-1:0] level);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        brightness = level;
    endtask

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(9))
            0: return '0;
            1: return FULL_SCALE;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic test_sector_starts();
        send_pixel(9'd0, 8'd200, 8'd230);
        send_pixel(9'd60, 8'd200, 8'd230);
        send_pixel(9'd120, 8'd200, 8'd230);
        send_pixel(9'd180, 8'd200, 8'd230);
        send_pixel(9'd240, 8'd200, 8'd230);
        send_pixel(9'd300, 8'd200, 8'd230);
        send_pixel(9'd59, 8'd255, 8'd255);
        send_pixel(9'd359, 8'd255, 8'd255);
    endtask

    task automatic test_field_extremes();
        send_pixel(9'd0, 8'd0, 8'd255);
        send_pixel(9'd30, 8'd255, 8'd0);
        send_pixel(9'd90, 8'd0, 8'd0);
        send_pixel(9'd150, 8'd255, 8'd255);
        send_pixel(9'd45, 8'd128, 8'd1);
    endtask

    task automatic test_hue_out_of_range();
        send_pixel(9'd360, 8'd255, 8'd255);
        send_pixel(9'd511, 8'd17, 8'd200);
        send_pixel(9'd384, 8'd0, 8'd0);
    endtask

    task automatic test_brightness_extremes();
        set_brightness(8'd0);
        send_pixel(9'd10, 8'd255, 8'd255);
        send_pixel(9'd200, 8'd100, 8'd180);
        set_brightness(8'd128);
        send_pixel(9'd10, 8'd255, 8'd255);
        send_pixel(9'd280, 8'd60, 8'd250);
        set_brightness(FULL_SCALE);
        send_pixel(9'd100, 8'd255, 8'd255);
        send_pixel(9'd330, 8'd90, 8'd140);
    endtask

    task automatic test_random_pixels(input int send_pct, input int recv_pct, input int count);
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;

        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int chunk = 0; chunk < 5; chunk++) begin
            set_brightness(pick_level());
            repeat (count / 5) begin
                if ($urandom_range(99) < 12)
                    hue = HUE_W'($urandom_range(511, 360));
                else
                    hue = HUE_W'($urandom_range(359, 0));
                sat = ($urandom_range(9) == 0) ? {CHAN_W{$urandom_range(1) == 1}}
                                               : CHAN_W'($urandom_range(255));
                val = ($urandom_range(9) == 0) ? {CHAN_W{$urandom_range(1) == 1}}
                                               : CHAN_W'($urandom_range(255));
                send_pixel(hue, sat, val);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sector_starts();
        test_field_extremes();
        test_hue_out_of_range();
        test_brightness_extremes();
        test_random_pixels(12, 84, 350);
        test_random_pixels(84, 12, 350);
        test_random_pixels(0, 0, 350);
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_hsv_to_rgb_converter_core OK");
        else
            $display("tb_hsv_to_rgb_converter_core NOT OK");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_hsv_to_rgb_converter_core NOT OK");
        $finish;
    end

endmodule
